FILE: sv/awtm_pkg.sv
// Shared types, constants and elaboration-time trig tables for the tilt/motion block.
package awtm_pkg;

    localparam int WINDOW_LEN = 10;
    localparam int CNT_W      = $clog2(WINDOW_LEN);
    localparam int AXIS_W     = 16;
    localparam int SUM_W      = 20;
    localparam int SQ_W       = 32;
    localparam int MAG_W      = 16;
    localparam int BIT_W      = 4;
    localparam int ANG_W      = 9;
    localparam int K_W        = 6;
    localparam int TAB_N      = 46;
    localparam int TAB_W      = 47;
    localparam int MUL_A_W    = SUM_W;
    localparam int MUL_B_W    = TAB_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    // average by reciprocal multiply: floor(n * RECIP >> RECIP_SH) == n / WINDOW_LEN
    // for every |sum| below 2^20 and WINDOW_LEN up to 16
    localparam int RECIP_SH = 24;
    localparam logic [MUL_B_W-1:0] RECIP =
        MUL_B_W'(((64'd1 << RECIP_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    localparam logic [K_W-1:0] K_LAST = K_W'(44);
    localparam logic [K_W-1:0] K_DIAG = K_W'(45);

    localparam logic [127:0] PI_Q60  = 128'h3243F6A8885A308D;
    localparam logic [127:0] ONE_Q60 = 128'd1 << 60;

    typedef logic [TAB_N-1:0][TAB_W-1:0] tab_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_SQA,
        S_RT_MUL,
        S_RT_CMP,
        S_UPD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ANG_SET,
        S_ANG_M1,
        S_ANG_M2,
        S_ANG_CMP,
        S_ANG_FIN,
        S_OUT
    } state_t;

    // Q46 sin/cos per whole degree, truncating Taylor series on Q60 angles
    function automatic tab_t build_tab(input logic want_cos);
        logic [127:0] step;
        logic [127:0] r;
        logic [127:0] r2;
        logic [127:0] ts;
        logic [127:0] s;
        logic [127:0] tc;
        logic [127:0] c;
        tab_t t;
        step = PI_Q60 / 180;
        for (int k = 0; k < TAB_N; k++)
        begin
            r  = step * 128'(k);
            r2 = (r * r) >> 60;
            ts = r;
            s  = r;
            tc = ONE_Q60;
            c  = ONE_Q60;
            for (int n = 1; n <= 12; n++)
            begin
                ts = ((ts * r2) >> 60) / 128'((2 * n) * (2 * n + 1));
                tc = ((tc * r2) >> 60) / 128'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                begin
                    s = s - ts;
                    c = c - tc;
                end
                else
                begin
                    s = s + ts;
                    c = c + tc;
                end
            end
            t[k] = want_cos ? c[60:14] : s[60:14];
        end
        return t;
    endfunction

    localparam tab_t SIN_TAB = build_tab(1'b0);
    localparam tab_t COS_TAB = build_tab(1'b1);

endpackage

FILE: sv/awtm_if.sv
// Request channels: sample input and tilt/motion result output.
interface awtm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [awtm_pkg::AXIS_W-1:0]  accel_x;
    logic signed [awtm_pkg::AXIS_W-1:0]  accel_y;
    logic signed [awtm_pkg::AXIS_W-1:0]  accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface awtm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [awtm_pkg::ANG_W-1:0]   tilt_main_deg;
    logic signed [awtm_pkg::ANG_W-1:0]   tilt_side_deg;
    logic        [awtm_pkg::MAG_W-1:0]   max_magnitude_jump;

    modport source (output valid, output tilt_main_deg, output tilt_side_deg,
                    output max_magnitude_jump, input ready);
    modport sink   (input valid, input tilt_main_deg, input tilt_side_deg,
                    input max_magnitude_jump, output ready);
endinterface

FILE: sv/awtm_mul.sv
// Shared registered multiplier: squares, root trials, average reciprocal multiplies and trig cross products.
module awtm_mul (
    input  logic                           clk,
    input  logic [awtm_pkg::MUL_A_W-1:0]   a,
    input  logic [awtm_pkg::MUL_B_W-1:0]   b,
    output logic [awtm_pkg::MUL_P_W-1:0]   prod
);
    import awtm_pkg::*;

    always_ff @(posedge clk)
    begin
        prod <= MUL_P_W'(a) * MUL_P_W'(b);
    end

endmodule

FILE: sv/awtm_div.sv
// Window average by reciprocal multiply on the shared multiplier: operands out, quotient back.
module awtm_div (
    input  logic signed [awtm_pkg::SUM_W-1:0]  sum,
    input  logic [awtm_pkg::MUL_P_W-1:0]       prod,
    output logic [awtm_pkg::MUL_A_W-1:0]       mul_a,
    output logic [awtm_pkg::MUL_B_W-1:0]       mul_b,
    output logic [awtm_pkg::MAG_W-1:0]         quotient,
    output logic                               negative
);
    import awtm_pkg::*;

    // magnitude times reciprocal, sign kept aside (truncation toward zero)
    assign mul_a    = sum[SUM_W-1] ? MUL_A_W'(-sum) : MUL_A_W'(sum);
    assign mul_b    = RECIP;
    assign quotient = prod[RECIP_SH +: MAG_W];
    assign negative = sum[SUM_W-1] && (quotient != '0);

endmodule

FILE: sv/accel_window_tilt_motion.sv
// Top level: windowed accelerometer tilt angles and peak magnitude jump.
//
// Usage: one three-axis sample is offered per request on in_ch; the block
// takes it when in_ch.ready is high, which it raises only while idle. Each
// sample passes through the accept step, a sum of squares, a 16-step square
// root on the one shared multiplier (a trial square per step), and an update
// step. The sample that completes a window of WINDOW_LEN additionally runs
// three reciprocal multiplies for the axis averages and two angle searches
// (up to 44 degrees tested each) on the same multiplier, plus an output step;
// then one result request appears on out_ch.
// The result sits in its own register: if the receiver stalls, the block
// still takes and processes further samples and only waits when a second
// result is ready before the first was taken.
// Reset clears the window (count, sums, previous magnitude, peak jump), the
// sequencer and the output valid; no result is pending after reset.
module accel_window_tilt_motion (
    input  logic        clk,
    input  logic        rst_n,
    awtm_in_if.sink     in_ch,
    awtm_out_if.source  out_ch
);
    import awtm_pkg::*;

    state_t state_reg, state_next;

    // sample and root iteration
    logic signed [AXIS_W-1:0] x_reg, y_reg, z_reg;
    logic [SQ_W-1:0]          acc_reg, acc_next;
    logic [MAG_W-1:0]         root_reg, root_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;

    // window state
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic signed [SUM_W-1:0]  sum_z_reg, sum_z_next;
    logic [MAG_W-1:0]         prev_mag_reg, prev_mag_next;
    logic [MAG_W-1:0]         max_jump_reg, max_jump_next;

    // averages as magnitude plus negative flag
    logic [1:0]               axis_reg, axis_next;
    logic [MAG_W-1:0]         avg_x_reg, avg_x_next;
    logic [MAG_W-1:0]         avg_y_reg, avg_y_next;
    logic [MAG_W-1:0]         avg_z_reg, avg_z_next;
    logic                     neg_x_reg, neg_x_next;
    logic                     neg_y_reg, neg_y_next;
    logic                     neg_z_reg, neg_z_next;

    // angle search
    logic                     sel_reg, sel_next;
    logic [MAG_W-1:0]         p_reg, p_next;
    logic [MAG_W-1:0]         q_reg, q_next;
    logic                     swap_reg, swap_next;
    logic                     exact_reg, exact_next;
    logic                     zero_reg, zero_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [MUL_P_W-1:0]       lhs_reg, lhs_next;
    logic signed [ANG_W-1:0]  main_reg, main_next;
    logic signed [ANG_W-1:0]  side_reg, side_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic signed [ANG_W-1:0]  out_main_reg, out_main_next;
    logic signed [ANG_W-1:0]  out_side_reg, out_side_next;
    logic [MAG_W-1:0]         out_jump_reg, out_jump_next;

    // shared units
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [MUL_P_W-1:0]       prod;
    logic [MUL_A_W-1:0]       div_mul_a;
    logic [MUL_B_W-1:0]       div_mul_b;
    logic [MAG_W-1:0]         div_quo;
    logic                     div_neg;

    // helpers
    logic [MAG_W-1:0]         abs_x, abs_y, abs_z;
    logic [MAG_W-1:0]         trial;
    logic [MAG_W-1:0]         jump;
    logic signed [SUM_W-1:0]  div_sum;
    logic [MAG_W-1:0]         ang_ay;
    logic                     ang_yneg;
    logic [K_W:0]             ang_c;
    logic [7:0]               ang_pf, ang_pc, ang_mag;
    logic signed [ANG_W-1:0]  ang_res;
    logic                     window_end;
    logic                     out_take;

    awtm_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // divide operands go out in S_DIV_GO, registered product comes back in S_DIV_WAIT
    awtm_div u_div (
        .sum      (div_sum),
        .prod     (prod),
        .mul_a    (div_mul_a),
        .mul_b    (div_mul_b),
        .quotient (div_quo),
        .negative (div_neg)
    );

    assign abs_x = x_reg[AXIS_W-1] ? MAG_W'(-x_reg) : MAG_W'(x_reg);
    assign abs_y = y_reg[AXIS_W-1] ? MAG_W'(-y_reg) : MAG_W'(y_reg);
    assign abs_z = z_reg[AXIS_W-1] ? MAG_W'(-z_reg) : MAG_W'(z_reg);
    assign trial = root_reg | (MAG_W'(1) << bit_reg);
    assign jump  = (root_reg > prev_mag_reg) ? (root_reg - prev_mag_reg)
                                             : (prev_mag_reg - root_reg);
    assign window_end = (cnt_reg == CNT_W'(WINDOW_LEN - 1));
    assign out_take   = out_valid_reg && out_ch.ready;

    always_comb
    begin
        case (axis_reg)
            2'd0:    div_sum = sum_x_reg;
            2'd1:    div_sum = sum_y_reg;
            default: div_sum = sum_z_reg;
        endcase
    end

    // final angle assembly from the floor degree k
    assign ang_ay   = sel_reg ? avg_z_reg : avg_y_reg;
    assign ang_yneg = sel_reg ? neg_z_reg : neg_y_reg;
    assign ang_c    = exact_reg ? {1'b0, k_reg} : ({1'b0, k_reg} + 1'b1);
    assign ang_pf   = swap_reg ? (8'd90 - 8'(ang_c)) : 8'(k_reg);
    assign ang_pc   = swap_reg ? (8'd90 - 8'(k_reg)) : 8'(ang_c);
    assign ang_mag  = neg_x_reg ? (8'd180 - ang_pc) : ang_pf;
    assign ang_res  = zero_reg ? '0 :
                      (ang_yneg ? -$signed(ANG_W'(ang_mag)) : $signed(ANG_W'(ang_mag)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_ch.valid) state_next = S_SQX;
            S_SQX:      state_next = S_SQY;
            S_SQY:      state_next = S_SQZ;
            S_SQZ:      state_next = S_SQA;
            S_SQA:      state_next = S_RT_MUL;
            S_RT_MUL:   state_next = S_RT_CMP;
            S_RT_CMP:   state_next = (bit_reg == '0) ? S_UPD : S_RT_MUL;
            S_UPD:      state_next = window_end ? S_DIV_GO : S_IDLE;
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT: state_next = (axis_reg == 2'd2) ? S_ANG_SET : S_DIV_GO;
            S_ANG_SET:  state_next = S_ANG_M1;
            S_ANG_M1:
            begin
                if (zero_reg || exact_reg || k_reg == K_LAST)
                    state_next = S_ANG_FIN;
                else
                    state_next = S_ANG_M2;
            end
            S_ANG_M2:   state_next = S_ANG_CMP;
            S_ANG_CMP:  state_next = (lhs_reg >= prod) ? S_ANG_M1 : S_ANG_FIN;
            S_ANG_FIN:  state_next = sel_reg ? S_OUT : S_ANG_SET;
            S_OUT:      if (!out_valid_reg || out_ch.ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        in_ch.ready    = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        acc_next       = acc_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sum_z_next     = sum_z_reg;
        prev_mag_next  = prev_mag_reg;
        max_jump_next  = max_jump_reg;
        axis_next      = axis_reg;
        avg_x_next     = avg_x_reg;
        avg_y_next     = avg_y_reg;
        avg_z_next     = avg_z_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        neg_z_next     = neg_z_reg;
        sel_next       = sel_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        swap_next      = swap_reg;
        exact_next     = exact_reg;
        zero_next      = zero_reg;
        k_next         = k_reg;
        lhs_next       = lhs_reg;
        main_next      = main_reg;
        side_next      = side_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        out_main_next  = out_main_reg;
        out_side_next  = out_side_reg;
        out_jump_next  = out_jump_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            S_SQX:
            begin
                mul_a = MUL_A_W'(abs_x);
                mul_b = MUL_B_W'(abs_x);
            end
            S_SQY:
            begin
                mul_a    = MUL_A_W'(abs_y);
                mul_b    = MUL_B_W'(abs_y);
                acc_next = prod[SQ_W-1:0];
            end
            S_SQZ:
            begin
                mul_a    = MUL_A_W'(abs_z);
                mul_b    = MUL_B_W'(abs_z);
                acc_next = acc_reg + prod[SQ_W-1:0];
            end
            S_SQA:
            begin
                acc_next  = acc_reg + prod[SQ_W-1:0];
                root_next = '0;
                bit_next  = BIT_W'(MAG_W - 1);
            end
            S_RT_MUL:
            begin
                mul_a = MUL_A_W'(trial);
                mul_b = MUL_B_W'(trial);
            end
            S_RT_CMP:
            begin
                if (prod <= MUL_P_W'(acc_reg))
                    root_next = trial;
                bit_next = bit_reg - 1'b1;
            end
            S_UPD:
            begin
                // first sample of a window forms no jump
                if (cnt_reg != '0 && jump > max_jump_reg)
                    max_jump_next = jump;
                prev_mag_next = root_reg;
                sum_x_next    = sum_x_reg + SUM_W'(x_reg);
                sum_y_next    = sum_y_reg + SUM_W'(y_reg);
                sum_z_next    = sum_z_reg + SUM_W'(z_reg);
                cnt_next      = cnt_reg + 1'b1;
                axis_next     = 2'd0;
                sel_next      = 1'b0;
            end
            S_DIV_GO:
            begin
                mul_a = div_mul_a;
                mul_b = div_mul_b;
            end
            S_DIV_WAIT:
            begin
                case (axis_reg)
                    2'd0:
                    begin
                        avg_x_next = div_quo;
                        neg_x_next = div_neg;
                    end
                    2'd1:
                    begin
                        avg_y_next = div_quo;
                        neg_y_next = div_neg;
                    end
                    default:
                    begin
                        avg_z_next = div_quo;
                        neg_z_next = div_neg;
                    end
                endcase
                axis_next = axis_reg + 1'b1;
            end
            S_ANG_SET:
            begin
                // fold into the first octant: p <= q
                zero_next = (ang_ay == '0) && (avg_x_reg == '0);
                swap_next = ang_ay > avg_x_reg;
                if (ang_ay > avg_x_reg)
                begin
                    p_next = avg_x_reg;
                    q_next = ang_ay;
                end
                else
                begin
                    p_next = ang_ay;
                    q_next = avg_x_reg;
                end
                exact_next = (p_next == '0) || (p_next == q_next);
                k_next     = (p_next != '0 && p_next == q_next) ? K_DIAG : '0;
            end
            S_ANG_M1:
            begin
                mul_a = MUL_A_W'(p_reg);
                mul_b = COS_TAB[k_reg + 1'b1];
            end
            S_ANG_M2:
            begin
                mul_a    = MUL_A_W'(q_reg);
                mul_b    = SIN_TAB[k_reg + 1'b1];
                lhs_next = prod;
            end
            S_ANG_CMP:
            begin
                if (lhs_reg >= prod)
                    k_next = k_reg + 1'b1;
            end
            S_ANG_FIN:
            begin
                if (sel_reg)
                    side_next = ang_res;
                else
                    main_next = ang_res;
                sel_next = 1'b1;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_main_next  = main_reg;
                    out_side_next  = side_reg;
                    out_jump_next  = max_jump_reg;
                    cnt_next       = '0;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    sum_z_next     = '0;
                    prev_mag_next  = '0;
                    max_jump_next  = '0;
                end
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.tilt_main_deg      = out_main_reg;
    assign out_ch.tilt_side_deg      = out_side_reg;
    assign out_ch.max_magnitude_jump = out_jump_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            prev_mag_reg  <= '0;
            max_jump_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_z_reg     <= sum_z_next;
            prev_mag_reg  <= prev_mag_next;
            max_jump_reg  <= max_jump_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            x_reg <= in_ch.accel_x;
            y_reg <= in_ch.accel_y;
            z_reg <= in_ch.accel_z;
        end
        acc_reg      <= acc_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        axis_reg     <= axis_next;
        avg_x_reg    <= avg_x_next;
        avg_y_reg    <= avg_y_next;
        avg_z_reg    <= avg_z_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        neg_z_reg    <= neg_z_next;
        sel_reg      <= sel_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        swap_reg     <= swap_next;
        exact_reg    <= exact_next;
        zero_reg     <= zero_next;
        k_reg        <= k_next;
        lhs_reg      <= lhs_next;
        main_reg     <= main_next;
        side_reg     <= side_next;
        out_main_reg <= out_main_next;
        out_side_reg <= out_side_next;
        out_jump_reg <= out_jump_next;
    end

endmodule
